[sv/ccts_pkg.sv]
// ----------------------------------------------------------------------------
// ccts_pkg
// Shared types, codes, constants and the phase table entry function for the
// circadian color temperature scheduler.
// ----------------------------------------------------------------------------
package ccts_pkg;

   // default configuration of the block
   localparam int ROOM_COUNT_DEF       = 8;
   localparam int PHASE_TABLE_BITS_DEF = 10;

   // minutes in one day
   localparam int DAY_MINUTES = 1440;

   // rounding and output limits of the kelvin stage
   localparam int KELVIN_HALF = 3276800;
   localparam int KELVIN_STEP = 100;
   localparam int TEMP_OUT_MAX = 16300;

   // divide by 100 as a multiply by ceil(2^24 / 100) and a shift, exact below 2^16
   localparam logic [17:0] KELVIN_RECIP       = 18'd167773;
   localparam int          KELVIN_RECIP_SHIFT = 24;

   // register reset values
   localparam logic [13:0] MIN_TEMP_RESET = 14'd2000;
   localparam logic [13:0] MAX_TEMP_RESET = 14'd6500;

   // shared divider widths
   localparam int DIV_NUM_W = 27;
   localparam int DIV_DEN_W = 11;

   // request codes
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_ENABLE  = 2'd1;
   localparam logic [1:0] REQ_DISABLE = 2'd2;

   // result action codes
   localparam logic [1:0] ACT_SET_TEMP = 2'd0;
   localparam logic [1:0] ACT_OFF      = 2'd1;
   localparam logic [1:0] ACT_RESTORE  = 2'd2;

   // configuration register indexes
   localparam logic CSR_MIN_TEMP = 1'b0;
   localparam logic CSR_MAX_TEMP = 1'b1;

   // which division the shared divider runs
   typedef enum logic [1:0] {
      DIV_PHASE  = 2'd0,
      DIV_INTERP = 2'd1
   } div_sel_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  room;
      logic [10:0] wake_minute;
      logic [10:0] sleep_minute;
      logic [10:0] now_minute;
      logic [7:0]  base_red;
      logic [7:0]  base_green;
      logic [7:0]  base_blue;
   } ccts_req_type;

   typedef struct packed {
      logic [2:0]  target_room;
      logic [1:0]  action;
      logic [13:0] kelvin;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last_of_run;
   } ccts_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic        enable_wr;
      logic        dis_accept;
      logic        tick_accept;
      logic        next_room;
      logic        div_go;
      div_sel_type div_sel;
      logic        latch_phase;
      logic        tab_sel_b;
      logic        latch_ta;
      logic        latch_f_tab;
      logic        latch_f_div;
      logic        scale;
      logic        kelvin_sum;
      logic        kelvin_round;
      logic        emit_off;
      logic        emit_temp;
      logic        emit_color;
      logic        flush;
   } ccts_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_room_ok;
      logic req_room_enabled;
      logic any_enabled;
      logic cur_enabled;
      logic cur_last;
      logic in_window;
      logic light_on_cur;
      logic simple_phase;
      logic send_temp;
      logic div_done;
   } ccts_status_type;

   // sin^2(pi * i / 2^bits) in Q0.16, rounded, capped at full scale
   function automatic logic [15:0] phase_entry(int i, int bits);
      int  full;
      int  j;
      real step;
      real s;
      real v;
      int  e;
      full = 1 << bits;
      step = 1.0;
      for (int k = 0; k < bits; k++) step = step * 0.5;
      j = (i <= (full >> 1)) ? i : full - i;
      s = $sin(3.14159265358979323846 * j * step);
      v = s * s * 65536.0 + 0.5;
      e = $rtoi(v);
      if (e > 65535) e = 65535;
      return 16'(e);
   endfunction

endpackage

[sv/ccts_div.sv]
// ----------------------------------------------------------------------------
// ccts_div
// Radix-2 restoring divider, one quotient bit per cycle. Quotient and
// remainder hold until the next start.
// ----------------------------------------------------------------------------
module ccts_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] remd
);
   localparam int CNT_W = $clog2(NUM_W);

   logic             active_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;

   // one restoring step
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = DEN_W'(trial - {1'b0, den_ff});
         quo_in = {quo_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], 1'b0};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
         end else if (active_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   // operands
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (active_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign remd = rem_ff;
endmodule

[sv/ccts_datapath.sv]
// ----------------------------------------------------------------------------
// ccts_datapath
// Room state, minute clock, phase table, shared divider, kelvin scaling and
// the result staging registers.
// ----------------------------------------------------------------------------
module ccts_datapath #(
   parameter int ROOM_COUNT       = ccts_pkg::ROOM_COUNT_DEF,
   parameter int PHASE_TABLE_BITS = ccts_pkg::PHASE_TABLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ccts_pkg::ccts_req_type    req_data,
   input  logic                      csr_wr,
   input  logic                      csr_index,
   input  logic [13:0]               csr_data,
   input  ccts_pkg::ccts_cmd_type    cmd,
   output ccts_pkg::ccts_status_type status,
   output logic                      rsp_valid,
   output ccts_pkg::ccts_rsp_type    rsp_data
);
   import ccts_pkg::*;

   localparam int RIDX_W     = (ROOM_COUNT > 1) ? $clog2(ROOM_COUNT) : 1;
   localparam int TAB_SIZE   = (1 << PHASE_TABLE_BITS) + 1;
   localparam int TAB_W      = PHASE_TABLE_BITS + 1;

   typedef logic [15:0] tab_type [TAB_SIZE];

   function automatic tab_type build_tab();
      tab_type t;
      for (int i = 0; i < TAB_SIZE; i++) t[i] = phase_entry(i, PHASE_TABLE_BITS);
      return t;
   endfunction

   localparam tab_type PHASE_TAB = build_tab();

   // configuration
   logic [13:0] min_ff, max_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_TEMP_RESET;
         max_ff <= MAX_TEMP_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_MIN_TEMP: min_ff <= csr_data;
            CSR_MAX_TEMP: max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // request decode
   logic [RIDX_W-1:0] req_idx;
   logic              minutes_ok;
   logic [11:0]       len_wide;
   assign req_idx    = RIDX_W'(req_data.room);
   assign minutes_ok = (req_data.wake_minute < 11'(DAY_MINUTES)) &&
                       (req_data.sleep_minute < 11'(DAY_MINUTES)) &&
                       (req_data.now_minute < 11'(DAY_MINUTES));
   assign len_wide   = (req_data.sleep_minute < req_data.wake_minute) ?
                       12'(req_data.sleep_minute) + 12'(DAY_MINUTES) -
                       12'(req_data.wake_minute) :
                       12'(req_data.sleep_minute) - 12'(req_data.wake_minute);

   // per-room flags
   logic [ROOM_COUNT-1:0] enabled_ff, light_ff, lst_valid_ff, tim_valid_ff;
   logic [RIDX_W-1:0]     cur_ff;
   logic [10:0]           clock_ff;

   // room memories
   logic [21:0] timing_mem [ROOM_COUNT];
   logic [23:0] color_mem  [ROOM_COUNT];
   logic [13:0] temp_mem   [ROOM_COUNT];
   logic [21:0] timing_q_ff;
   logic [23:0] color_q_ff;
   logic [13:0] temp_q_ff;

   logic [13:0] temp_new;

   always_ff @(posedge clock) begin
      if (cmd.enable_wr && minutes_ok)
         timing_mem[req_idx] <= {req_data.wake_minute, 11'(len_wide)};
      if (cmd.enable_wr && !enabled_ff[req_idx])
         color_mem[req_idx] <= {req_data.base_red, req_data.base_green,
                                req_data.base_blue};
      if (cmd.emit_temp) temp_mem[cur_ff] <= temp_new;
      timing_q_ff <= timing_mem[cur_ff];
      color_q_ff  <= color_mem[cur_ff];
      temp_q_ff   <= temp_mem[cur_ff];
   end

   // flags, room pointer and minute clock
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= '0;
         light_ff     <= '1;
         lst_valid_ff <= '0;
         tim_valid_ff <= '0;
         cur_ff       <= '0;
         clock_ff     <= '0;
      end else begin
         if (cmd.enable_wr) begin
            enabled_ff[req_idx] <= 1'b1;
            if (minutes_ok) begin
               clock_ff              <= req_data.now_minute;
               tim_valid_ff[req_idx] <= 1'b1;
            end
         end
         if (cmd.dis_accept) begin
            enabled_ff[req_idx] <= 1'b0;
            cur_ff              <= req_idx;
         end
         if (cmd.tick_accept) cur_ff <= '0;
         if (cmd.next_room) cur_ff <= cur_ff + 1'b1;
         if (cmd.emit_off) light_ff[cur_ff] <= 1'b0;
         if (cmd.emit_temp) begin
            light_ff[cur_ff]     <= 1'b1;
            lst_valid_ff[cur_ff] <= 1'b1;
         end
         if (cmd.flush)
            clock_ff <= (clock_ff == 11'(DAY_MINUTES - 1)) ? '0 : clock_ff + 1'b1;
      end
   end

   // window check, never-loaded timing reads as zero
   logic [21:0] timing_cur;
   logic [10:0] wake_cur, len_cur, since_wake;
   logic [11:0] since_wake_wide;
   logic [13:0] lst_cur;
   assign timing_cur      = tim_valid_ff[cur_ff] ? timing_q_ff : '0;
   assign wake_cur        = timing_cur[21:11];
   assign len_cur         = timing_cur[10:0];
   assign since_wake_wide = (clock_ff >= wake_cur) ? 12'(clock_ff) - 12'(wake_cur) :
                            12'(clock_ff) + 12'(DAY_MINUTES) - 12'(wake_cur);
   assign since_wake      = 11'(since_wake_wide);
   assign lst_cur         = lst_valid_ff[cur_ff] ? temp_q_ff : '0;

   // shared divider
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_numer, div_quot;
   logic [DIV_DEN_W-1:0] div_denom, div_rem;
   logic [TAB_W-1:0]     idx_ff;
   logic [10:0]          rem_ff;
   logic [15:0]          ta_ff, tab_q_ff, f_ff;
   logic signed [31:0]   prod_ff;
   logic signed [32:0]   sc, sc_pos, sc_sum;
   logic [27:0]          interp_num;

   assign interp_num = 28'(ta_ff) * 28'(len_cur - rem_ff) +
                       28'(tab_q_ff) * 28'(rem_ff) + 28'(len_cur >> 1);
   assign sc     = $signed({3'b000, min_ff, 16'h0000}) + 33'(prod_ff);
   assign sc_pos = sc[32] ? '0 : sc;
   assign sc_sum = sc_pos + 33'(KELVIN_HALF);

   always_comb begin
      case (cmd.div_sel)
         DIV_PHASE: begin
            div_numer = DIV_NUM_W'({since_wake, {PHASE_TABLE_BITS{1'b0}}});
            div_denom = len_cur;
         end
         DIV_INTERP: begin
            div_numer = DIV_NUM_W'(interp_num);
            div_denom = len_cur;
         end
         default: begin
            div_numer = '0;
            div_denom = len_cur;
         end
      endcase
   end

   ccts_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot),
      .remd  (div_rem)
   );

   // phase table read port
   logic [TAB_W-1:0] tab_addr;
   assign tab_addr = cmd.tab_sel_b ? idx_ff + 1'b1 : idx_ff;
   always_ff @(posedge clock) begin
      tab_q_ff <= PHASE_TAB[tab_addr];
   end

   // curve operands
   always_ff @(posedge clock) begin
      if (cmd.latch_phase) begin
         idx_ff <= TAB_W'(div_quot);
         rem_ff <= div_rem;
      end
      if (cmd.latch_ta) ta_ff <= tab_q_ff;
      if (cmd.latch_f_tab) f_ff <= tab_q_ff;
      if (cmd.latch_f_div) f_ff <= 16'(div_quot);
      if (cmd.scale)
         prod_ff <= ($signed({1'b0, max_ff}) - $signed({1'b0, min_ff})) *
                    $signed({1'b0, f_ff});
   end

   // kelvin in hundreds: rounded sum, then divide by 100 by reciprocal
   logic [15:0] ksum_ff;
   logic [9:0]  kq_ff;
   logic [33:0] kq_prod;
   assign kq_prod = 34'(ksum_ff) * 34'(KELVIN_RECIP);
   always_ff @(posedge clock) begin
      if (cmd.kelvin_sum) ksum_ff <= sc_sum[31:16];
      if (cmd.kelvin_round) kq_ff <= kq_prod[KELVIN_RECIP_SHIFT +: 10];
   end

   // rounded kelvin, saturated
   logic [22:0] hundreds;
   assign hundreds = 23'(kq_ff) * 23'(KELVIN_STEP);
   assign temp_new = (hundreds > 23'(TEMP_OUT_MAX)) ? 14'(TEMP_OUT_MAX) : 14'(hundreds);

   // status back to the controller
   always_comb begin
      status.req_room_ok      = (32'(req_data.room) < ROOM_COUNT);
      status.req_room_enabled = enabled_ff[req_idx];
      status.any_enabled      = |enabled_ff;
      status.cur_enabled      = enabled_ff[cur_ff];
      status.cur_last         = (cur_ff == RIDX_W'(ROOM_COUNT - 1));
      status.in_window        = (len_cur != '0) && (since_wake <= len_cur);
      status.light_on_cur     = light_ff[cur_ff];
      status.simple_phase     = (rem_ff == '0) || (idx_ff == TAB_W'(TAB_SIZE - 1));
      status.send_temp        = (temp_new != lst_cur) || !light_ff[cur_ff];
      status.div_done         = div_done;
   end

   // new result item
   ccts_rsp_type new_item;
   always_comb begin
      new_item             = '0;
      new_item.target_room = 3'(cur_ff);
      if (cmd.emit_temp) begin
         new_item.action = ACT_SET_TEMP;
         new_item.kelvin = temp_new;
      end else begin
         new_item.action = ACT_OFF;
      end
   end

   // one pending beat so the last of a run can be marked
   ccts_rsp_type pend_ff, rsp_ff, rsp_in;
   logic         pend_valid_ff, rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cmd.emit_off || cmd.emit_temp) begin
            pend_valid_ff <= 1'b1;
            if (pend_valid_ff) rsp_valid_ff <= 1'b1;
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
            if (pend_valid_ff) rsp_valid_ff <= 1'b1;
         end
         if (cmd.emit_color) rsp_valid_ff <= 1'b1;
      end
   end

   // next output beat
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit_off || cmd.emit_temp) begin
         rsp_in             = pend_ff;
         rsp_in.last_of_run = 1'b0;
      end
      if (cmd.flush) begin
         rsp_in             = pend_ff;
         rsp_in.last_of_run = 1'b1;
      end
      if (cmd.emit_color) begin
         rsp_in             = '0;
         rsp_in.target_room = 3'(cur_ff);
         rsp_in.action      = ACT_RESTORE;
         rsp_in.red         = color_q_ff[23:16];
         rsp_in.green       = color_q_ff[15:8];
         rsp_in.blue        = color_q_ff[7:0];
         rsp_in.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_off || cmd.emit_temp) pend_ff <= new_item;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[sv/ccts_ctrl.sv]
// ----------------------------------------------------------------------------
// ccts_ctrl
// Sequencer: takes requests, walks the rooms on a tick and steps the curve
// evaluation through the shared divider and the phase table.
// ----------------------------------------------------------------------------
module ccts_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_kind,
   input  ccts_pkg::ccts_status_type status,
   output logic                      busy,
   output ccts_pkg::ccts_cmd_type    cmd
);
   import ccts_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE     = 15'h0001,
      S_DIS_RD   = 15'h0002,
      S_DIS_EMIT = 15'h0004,
      S_SCAN     = 15'h0008,
      S_CHK      = 15'h0010,
      S_DIV_PH   = 15'h0020,
      S_TAB_A    = 15'h0040,
      S_TAB_B    = 15'h0080,
      S_INTERP   = 15'h0100,
      S_DIV_F    = 15'h0200,
      S_SCALE    = 15'h0400,
      S_SUM      = 15'h0800,
      S_ROUND    = 15'h1000,
      S_FIN      = 15'h2000,
      S_FLUSH    = 15'h4000
   } ccts_state_type;

   ccts_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_PHASE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_kind)
                  REQ_ENABLE: cmd.enable_wr = status.req_room_ok;
                  REQ_DISABLE: begin
                     if (status.req_room_ok && status.req_room_enabled) begin
                        cmd.dis_accept = 1'b1;
                        state_in       = S_DIS_RD;
                     end
                  end
                  REQ_TICK: begin
                     if (status.any_enabled) begin
                        cmd.tick_accept = 1'b1;
                        state_in        = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIS_RD: state_in = S_DIS_EMIT;
         S_DIS_EMIT: begin
            cmd.emit_color = 1'b1;
            state_in       = S_IDLE;
         end
         S_SCAN: begin
            if (status.cur_enabled) state_in = S_CHK;
            else if (status.cur_last) state_in = S_FLUSH;
            else cmd.next_room = 1'b1;
         end
         S_CHK: begin
            if (status.in_window) begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = DIV_PHASE;
               state_in    = S_DIV_PH;
            end else begin
               cmd.emit_off = status.light_on_cur;
               if (status.cur_last) state_in = S_FLUSH;
               else begin
                  cmd.next_room = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         S_DIV_PH: begin
            if (status.div_done) begin
               cmd.latch_phase = 1'b1;
               state_in        = S_TAB_A;
            end
         end
         S_TAB_A: state_in = S_TAB_B;
         S_TAB_B: begin
            cmd.tab_sel_b = 1'b1;
            if (status.simple_phase) begin
               cmd.latch_f_tab = 1'b1;
               state_in        = S_SCALE;
            end else begin
               cmd.latch_ta = 1'b1;
               state_in     = S_INTERP;
            end
         end
         S_INTERP: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_INTERP;
            state_in    = S_DIV_F;
         end
         S_DIV_F: begin
            if (status.div_done) begin
               cmd.latch_f_div = 1'b1;
               state_in        = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_SUM;
         end
         S_SUM: begin
            cmd.kelvin_sum = 1'b1;
            state_in       = S_ROUND;
         end
         S_ROUND: begin
            cmd.kelvin_round = 1'b1;
            state_in         = S_FIN;
         end
         S_FIN: begin
            cmd.emit_temp = status.send_temp;
            if (status.cur_last) state_in = S_FLUSH;
            else begin
               cmd.next_room = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
endmodule

[sv/circadian_color_temp_scheduler.sv]
// ----------------------------------------------------------------------------
// circadian_color_temp_scheduler
// Per-room raised-cosine color temperature scheduling on minute ticks.
// ----------------------------------------------------------------------------
// Enable gives no result. Disable gives its restore beat as busy falls. A
// tick walks the rooms one after the other; for a room inside its window the
// 27-step shared divider runs twice (phase and interpolation), or once when
// the phase lands on a table entry. Results come as single-cycle strobes on
// rsp_valid, possibly on consecutive cycles, and cannot be held off; the
// last beat of a tick appears in the first cycle with busy low.
// csr_ready is always high; write the registers only while busy is low.
module circadian_color_temp_scheduler #(
   parameter int ROOM_COUNT       = ccts_pkg::ROOM_COUNT_DEF,
   parameter int PHASE_TABLE_BITS = ccts_pkg::PHASE_TABLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ccts_pkg::ccts_req_type req_data,
   output logic                   rsp_valid,
   output ccts_pkg::ccts_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [13:0]            csr_data
);
   import ccts_pkg::*;

   ccts_cmd_type    cmd;
   ccts_status_type status;

   assign csr_ready = 1'b1;

   ccts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.req_type),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   ccts_datapath #(
      .ROOM_COUNT       (ROOM_COUNT),
      .PHASE_TABLE_BITS (PHASE_TABLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // results only come out of work started earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without work in progress");

   // nothing follows the last beat of a run in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |=> !rsp_valid)
      else $error("beat right after the last of a run");

   // only a restore carries a color
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != ACT_RESTORE |->
         rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0)
      else $error("color on a non-restore beat");

   // a temperature beat stays within the output limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == ACT_SET_TEMP |->
         rsp_data.kelvin <= 14'(TEMP_OUT_MAX))
      else $error("temperature beyond limit");
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circadian color temperature scheduler. Drives
// enable, disable and tick commands with random gaps, predicts every light
// beat from its own model of the room schedules, and checks each beat in order
// across several min/max kelvin settings.
// ----------------------------------------------------------------------------
module tb;
   import ccts_pkg::*;

   localparam int ROOMS      = ROOM_COUNT_DEF;
   localparam int TAB_BITS   = PHASE_TABLE_BITS_DEF;
   localparam int TAB_FULL   = 1 << TAB_BITS;
   localparam int STALL_MAX  = 20000;
   localparam int SETTLE_CYC = 1000;

   typedef logic bool_t;

   // light schedule predictor and pending beat store
   class light_scoreboard;
      logic [15:0]  curve_tab [TAB_FULL+1];
      logic [13:0]  min_k, max_k;
      logic [10:0]  clock_min;
      logic         enabled [ROOMS];
      logic [10:0]  wake [ROOMS];
      logic [10:0]  awake_len [ROOMS];
      logic [23:0]  color [ROOMS];
      logic [13:0]  last_k [ROOMS];
      logic         lit [ROOMS];
      ccts_rsp_type pending_beats [$];
      int           errors;
      int           beats_seen;

      function new();
         int  j;
         real s;
         int  e;
         for (int i = 0; i <= TAB_FULL; i++) begin
            j = (i <= TAB_FULL / 2) ? i : TAB_FULL - i;
            s = $sin(3.14159265358979323846 * j / TAB_FULL);
            e = $rtoi(s * s * 65536.0 + 0.5);
            curve_tab[i] = (e > 65535) ? 16'hFFFF : 16'(e);
         end
         min_k = MIN_TEMP_RESET;
         max_k = MAX_TEMP_RESET;
         clock_min = '0;
         for (int r = 0; r < ROOMS; r++) begin
            enabled[r] = 0; wake[r] = 0; awake_len[r] = 0;
            color[r] = 0; last_k[r] = 0; lit[r] = 1;
         end
         errors = 0;
         beats_seen = 0;
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      function void set_reg(logic idx, logic [13:0] val);
         if (idx == CSR_MIN_TEMP) min_k = val; else max_k = val;
      endfunction

      // raised-cosine kelvin for d minutes into a window of len minutes
      function logic [13:0] kelvin_at(int unsigned d, int unsigned len);
         int unsigned num, idx, rem;
         longint      f, sc, h;
         num = d << TAB_BITS;
         idx = num / len;
         rem = num % len;
         if (idx >= TAB_FULL || rem == 0)
            f = curve_tab[(idx <= TAB_FULL) ? idx : TAB_FULL];
         else
            f = (longint'(curve_tab[idx]) * (len - rem) +
                 longint'(curve_tab[idx+1]) * rem + len / 2) / len;
         sc = longint'(min_k) * 65536 + (longint'(max_k) - longint'(min_k)) * f;
         if (sc < 0) sc = 0;
         h = ((sc + KELVIN_HALF) / 6553600) * KELVIN_STEP;
         if (h > TEMP_OUT_MAX) h = TEMP_OUT_MAX;
         return 14'(h);
      endfunction

      function void push_beat(int r, logic [1:0] act, logic [13:0] k, logic [23:0] c);
         ccts_rsp_type b;
         b.target_room = 3'(r);
         b.action      = act;
         b.kelvin      = k;
         b.red         = c[23:16];
         b.green       = c[15:8];
         b.blue        = c[7:0];
         b.last_of_run = 1'b0;
         pending_beats.push_back(b);
      endfunction

      function void note_command(ccts_req_type q);
         int          n0;
         bool_t       any;
         int unsigned t, d, len;
         logic [13:0] k;
         n0 = pending_beats.size();
         case (q.req_type)
            REQ_ENABLE: begin
               if (q.wake_minute < DAY_MINUTES && q.sleep_minute < DAY_MINUTES &&
                   q.now_minute < DAY_MINUTES) begin
                  wake[q.room] = q.wake_minute;
                  awake_len[q.room] = 11'((q.sleep_minute < q.wake_minute) ?
                     q.sleep_minute + DAY_MINUTES - q.wake_minute :
                     q.sleep_minute - q.wake_minute);
                  clock_min = q.now_minute;
               end
               if (!enabled[q.room]) begin
                  color[q.room] = {q.base_red, q.base_green, q.base_blue};
                  enabled[q.room] = 1;
               end
            end
            REQ_DISABLE: begin
               if (enabled[q.room]) begin
                  enabled[q.room] = 0;
                  push_beat(q.room, ACT_RESTORE, 0, color[q.room]);
               end
            end
            REQ_TICK: begin
               any = 0;
               for (int r = 0; r < ROOMS; r++) if (enabled[r]) any = 1;
               if (any) begin
                  t = clock_min;
                  for (int r = 0; r < ROOMS; r++) begin
                     if (enabled[r]) begin
                        len = awake_len[r];
                        d = (t >= wake[r]) ? t - wake[r] : t + DAY_MINUTES - wake[r];
                        if (len == 0 || d > len) begin
                           if (lit[r]) begin
                              push_beat(r, ACT_OFF, 0, 0);
                              lit[r] = 0;
                           end
                        end else begin
                           k = kelvin_at(d, len);
                           if (k != last_k[r] || !lit[r]) begin
                              push_beat(r, ACT_SET_TEMP, k, 0);
                              lit[r] = 1;
                              last_k[r] = k;
                           end
                        end
                     end
                  end
                  clock_min = 11'((t + 1) % DAY_MINUTES);
               end
            end
            default: ;
         endcase
         if (pending_beats.size() > n0)
            pending_beats[pending_beats.size()-1].last_of_run = 1'b1;
      endfunction

      task check_beat(ccts_rsp_type got);
         ccts_rsp_type want;
         beats_seen++;
         if (pending_beats.size() == 0) begin
            report($sformatf("unexpected beat room %0d action %0d",
                             got.target_room, got.action));
         end else begin
            want = pending_beats.pop_front();
            if (got.target_room != want.target_room)
               report($sformatf("target_room %0d, want %0d", got.target_room,
                                want.target_room));
            if (got.action != want.action)
               report($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.kelvin != want.kelvin)
               report($sformatf("kelvin %0d, want %0d (room %0d)",
                                got.kelvin, want.kelvin, want.target_room));
            if (got.red != want.red)
               report($sformatf("red %0d, want %0d", got.red, want.red));
            if (got.green != want.green)
               report($sformatf("green %0d, want %0d", got.green, want.green));
            if (got.blue != want.blue)
               report($sformatf("blue %0d, want %0d", got.blue, want.blue));
            if (got.last_of_run != want.last_of_run)
               report($sformatf("last_of_run %0d, want %0d", got.last_of_run,
                                want.last_of_run));
         end
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         start = 0;
   logic         busy;
   ccts_req_type req_data = '0;
   logic         rsp_valid;
   ccts_rsp_type rsp_data;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_index = 0;
   logic [13:0]  csr_data = '0;

   light_scoreboard sb = new();
   bit              gaps_on = 1;
   int              commands_sent = 0;
   int              stall_cycles = 0;

   circadian_color_temp_scheduler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_beat(rsp_data);
   end

   // watchdog on cycles with no beat moving anywhere
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_valid)
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_MAX) begin
         $display("watchdog expired after %0d quiet cycles", STALL_MAX);
         $display("simulation failed");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   // random gap on the command side
   task maybe_gap();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // one command beat, left high at the accepting edge
   task send_cmd(ccts_req_type q);
      start <= 1;
      req_data <= q;
      do @(posedge clock); while (busy);
      sb.note_command(q);
      commands_sent++;
      maybe_gap();
   endtask

   task send_fields(logic [1:0] kind, logic [2:0] room, int wk, int sl, int nw,
                    logic [23:0] rgb);
      ccts_req_type q;
      q.req_type = kind;
      q.room = room;
      q.wake_minute = 11'(wk);
      q.sleep_minute = 11'(sl);
      q.now_minute = 11'(nw);
      {q.base_red, q.base_green, q.base_blue} = rgb;
      send_cmd(q);
   endtask

   // wait for the block to drain before touching registers
   task drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task write_reg(logic idx, logic [13:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // random command mix, mostly valid schedules and ticks
   task random_cmds(int count);
      int          pick, wk, len;
      ccts_req_type q;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         q = '0;
         q.room = 3'($urandom_range(0, 7));
         {q.base_red, q.base_green, q.base_blue} = 24'($urandom);
         if (pick < 15) begin
            q.req_type = REQ_ENABLE;
            wk = $urandom_range(0, DAY_MINUTES - 1);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1439) :
                                                $urandom_range(0, 40);
            q.wake_minute = 11'(wk);
            q.sleep_minute = 11'((wk + len) % DAY_MINUTES);
            q.now_minute = 11'((wk + DAY_MINUTES - $urandom_range(0, 3)) % DAY_MINUTES);
         end else if (pick < 20) begin
            q.req_type = REQ_DISABLE;
         end else if (pick < 25) begin
            q.req_type = 2'($urandom_range(0, 3));
            q.wake_minute = 11'($urandom);
            q.sleep_minute = 11'($urandom);
            q.now_minute = 11'($urandom);
         end else begin
            q.req_type = REQ_TICK;
            q.wake_minute = 11'($urandom);
            q.sleep_minute = 11'($urandom);
            q.now_minute = 11'($urandom);
         end
         send_cmd(q);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default registers and the special cases
      write_reg(CSR_MIN_TEMP, MIN_TEMP_RESET);
      write_reg(CSR_MAX_TEMP, MAX_TEMP_RESET);
      send_fields(REQ_TICK, 0, 0, 0, 0, 0);              // tick with nothing enabled
      send_fields(REQ_DISABLE, 3, 0, 0, 0, 0);           // disable of idle room
      send_fields(2'd3, 5, 2047, 2047, 2047, 24'hFFFFFF);// unknown command
      send_fields(REQ_ENABLE, 0, 0, 0, 0, 24'h000000);   // zero length window
      send_fields(REQ_TICK, 0, 0, 0, 0, 0);
      send_fields(REQ_ENABLE, 7, 1439, 6, 1439, 24'hFFFFFF); // window past midnight
      for (int i = 0; i < 9; i++) send_fields(REQ_TICK, 0, 0, 0, 0, 0);
      send_fields(REQ_ENABLE, 7, 2047, 2047, 2047, 24'h123456); // bad minutes, re-enable
      send_fields(REQ_ENABLE, 2, 1440, 10, 0, 24'hA5C35A);  // bad minute, still enables
      send_fields(REQ_TICK, 0, 0, 0, 0, 0);
      send_fields(REQ_ENABLE, 7, 100, 99, 100, 24'h0F0F0F);  // near full-day window
      send_fields(REQ_TICK, 0, 0, 0, 0, 0);
      send_fields(REQ_DISABLE, 7, 0, 0, 0, 0);
      send_fields(REQ_DISABLE, 2, 0, 0, 0, 0);
      send_fields(REQ_DISABLE, 0, 0, 0, 0, 0);
      random_cmds(80);
      drain();

      // wide range, inverted range and register extremes
      write_reg(CSR_MIN_TEMP, 14'd1000);
      write_reg(CSR_MAX_TEMP, 14'd10000);
      random_cmds(100);
      drain();
      write_reg(CSR_MIN_TEMP, 14'd10000);
      write_reg(CSR_MAX_TEMP, 14'd1000);
      random_cmds(100);
      drain();
      write_reg(CSR_MIN_TEMP, 14'h3FFF);
      write_reg(CSR_MAX_TEMP, 14'd0);
      random_cmds(60);
      drain();
      write_reg(CSR_MIN_TEMP, 14'd0);
      write_reg(CSR_MAX_TEMP, 14'h3FFF);
      gaps_on = 0;
      random_cmds(135);
      drain();

      $display("ran %0d commands and checked %0d light beats over five kelvin settings",
               commands_sent, sb.beats_seen);
      if (sb.errors == 0 && sb.pending_beats.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

[files.f]
sv/ccts_pkg.sv
sv/ccts_div.sv
sv/ccts_datapath.sv
sv/ccts_ctrl.sv
sv/circadian_color_temp_scheduler.sv
tb/sv/tb.sv
